/* rtl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes, types and slot arithmetic for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic [2:0] action_t;

    localparam action_t ACT_INS_FRONT = 3'd0;
    localparam action_t ACT_INS_BACK  = 3'd1;
    localparam action_t ACT_DEL_FRONT = 3'd2;
    localparam action_t ACT_DEL_BACK  = 3'd3;
    localparam action_t ACT_UPD_VALUE = 3'd4;
    localparam action_t ACT_UPD_POS   = 3'd5;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_UPD,
        ENG_UPD_WAIT,
        ENG_READ
    } eng_state_t;

    typedef struct packed {
        status_t    status;
        logic [4:0] entry_count;
        logic [3:0] element_position;
        logic       list_empty;
        logic       last;
    } rd_meta_t;

    typedef struct packed {
        rd_meta_t           meta;
        logic signed [31:0] element;
    } out_item_t;

    typedef struct packed {
        logic [1:0] occ;
        logic       pop;
    } buf_stat_t;

    function automatic logic [PTR_W-1:0] slot_of(logic [PTR_W-1:0] front,
                                                  logic [CNT_W-1:0] idx);
        logic [PTR_W:0] sum;
        sum = {1'b0, front} + (PTR_W + 1)'(idx);
        if (sum >= (PTR_W + 1)'(DEPTH))
        begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

/* rtl/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH   = 32,
    parameter int ENTRIES = 16,
    parameter int ADDR_W  = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/bdq_out_buf.sv */
// ----------------------------------------------------------------------------
// bdq_out_buf
// Two-entry output queue that decouples the readout from the receiver.
// ----------------------------------------------------------------------------
module bdq_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bdq_pkg::out_item_t  push_item,
    output bdq_pkg::buf_stat_t  stat,
    output logic                out_valid,
    input  logic                out_ready,
    output bdq_pkg::out_item_t  out_item
);

    bdq_pkg::out_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    logic       pop;

    assign out_valid = (occ_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign stat.occ  = occ_reg;
    assign stat.pop  = pop;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        occ_next    = occ_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            occ_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // drop nothing: a push into a full queue without a pop loses an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && (occ_reg == 2'd2) && !pop))
        else $error("output queue overflow");

endmodule

/* rtl/bdq_engine.sv */
// ----------------------------------------------------------------------------
// bdq_engine
// Command sequencer: pointer and count state, RAM access, update walk and
// readout walk.
// ----------------------------------------------------------------------------
module bdq_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bdq_pkg::action_t                  action,
    input  logic [31:0]                       item_value,
    input  logic [31:0]                       match_value,
    input  logic [3:0]                        position,
    input  bdq_pkg::buf_stat_t                buf_stat,
    output logic                              push,
    output bdq_pkg::out_item_t                push_item,
    output logic                              ram_we,
    output logic [bdq_pkg::PTR_W-1:0]         ram_waddr,
    output logic [bdq_pkg::DATA_W-1:0]        ram_wdata,
    output logic                              ram_re,
    output logic [bdq_pkg::PTR_W-1:0]         ram_raddr,
    input  logic [bdq_pkg::DATA_W-1:0]        ram_rdata
);

    bdq_pkg::eng_state_t           state_reg;
    bdq_pkg::eng_state_t           state_next;
    logic [bdq_pkg::PTR_W-1:0]     front_reg;
    logic [bdq_pkg::PTR_W-1:0]     front_next;
    logic [bdq_pkg::CNT_W-1:0]     count_reg;
    logic [bdq_pkg::CNT_W-1:0]     count_next;
    bdq_pkg::status_t              status_reg;
    bdq_pkg::status_t              status_next;
    logic [bdq_pkg::DATA_W-1:0]    item_reg;
    logic [bdq_pkg::DATA_W-1:0]    item_next;
    logic [bdq_pkg::DATA_W-1:0]    match_reg;
    logic [bdq_pkg::DATA_W-1:0]    match_next;
    logic [bdq_pkg::CNT_W-1:0]     idx_reg;
    logic [bdq_pkg::CNT_W-1:0]     idx_next;
    logic                          cmp_valid_reg;
    logic                          cmp_valid_next;
    logic [bdq_pkg::PTR_W-1:0]     cmp_addr_reg;
    logic [bdq_pkg::PTR_W-1:0]     cmp_addr_next;
    logic                          stage_valid_reg;
    logic                          stage_valid_next;
    bdq_pkg::rd_meta_t             stage_meta_reg;
    bdq_pkg::rd_meta_t             stage_meta_next;

    logic [bdq_pkg::PTR_W-1:0]     front_dec;
    logic [bdq_pkg::PTR_W-1:0]     front_inc;
    logic                          full;
    logic                          empty;
    logic                          credit;
    logic                          last_idx;

    assign full     = (count_reg >= bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
    assign empty    = (count_reg == '0);
    assign last_idx = (idx_reg == count_reg - bdq_pkg::CNT_W'(1));
    assign credit   = ((3'(buf_stat.occ) + 3'(stage_valid_reg)) <= (3'd1 + 3'(buf_stat.pop)));

    assign front_dec = (front_reg == '0) ? bdq_pkg::PTR_W'(bdq_pkg::DEPTH - 1)
                                         : front_reg - bdq_pkg::PTR_W'(1);
    assign front_inc = (front_reg == bdq_pkg::PTR_W'(bdq_pkg::DEPTH - 1))
                       ? '0 : front_reg + bdq_pkg::PTR_W'(1);

    assign push              = stage_valid_reg;
    assign push_item.meta    = stage_meta_reg;
    assign push_item.element = stage_meta_reg.list_empty ? 32'sd0 : signed'(ram_rdata);

    always_comb
    begin
        state_next       = state_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        status_next      = status_reg;
        item_next        = item_reg;
        match_next       = match_reg;
        idx_next         = idx_reg;
        cmp_valid_next   = 1'b0;
        cmp_addr_next    = cmp_addr_reg;
        stage_valid_next = 1'b0;
        stage_meta_next  = stage_meta_reg;
        in_ready         = 1'b0;
        ram_re           = 1'b0;
        ram_raddr        = bdq_pkg::slot_of(front_reg, idx_reg);
        ram_we           = cmp_valid_reg && (ram_rdata == match_reg);
        ram_waddr        = cmp_addr_reg;
        ram_wdata        = item_reg;

        case (state_reg)
            bdq_pkg::ENG_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next   = item_value;
                    match_next  = match_value;
                    idx_next    = '0;
                    status_next = bdq_pkg::STAT_OK;
                    state_next  = bdq_pkg::ENG_READ;
                    case (action)
                        bdq_pkg::ACT_INS_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = bdq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                front_next = front_dec;
                                count_next = count_reg + bdq_pkg::CNT_W'(1);
                                ram_we     = 1'b1;
                                ram_waddr  = front_dec;
                                ram_wdata  = item_value;
                            end
                        end
                        bdq_pkg::ACT_INS_BACK:
                        begin
                            if (full)
                            begin
                                status_next = bdq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + bdq_pkg::CNT_W'(1);
                                ram_we     = 1'b1;
                                ram_waddr  = bdq_pkg::slot_of(front_reg, count_reg);
                                ram_wdata  = item_value;
                            end
                        end
                        bdq_pkg::ACT_DEL_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = bdq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                front_next = front_inc;
                                count_next = count_reg - bdq_pkg::CNT_W'(1);
                            end
                        end
                        bdq_pkg::ACT_DEL_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = bdq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - bdq_pkg::CNT_W'(1);
                            end
                        end
                        bdq_pkg::ACT_UPD_VALUE:
                        begin
                            if (!empty)
                            begin
                                state_next = bdq_pkg::ENG_UPD;
                            end
                        end
                        bdq_pkg::ACT_UPD_POS:
                        begin
                            if ({28'd0, position} >= 32'(count_reg))
                            begin
                                status_next = bdq_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = bdq_pkg::slot_of(front_reg,
                                                             bdq_pkg::CNT_W'(position));
                                ram_wdata = item_value;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bdq_pkg::ENG_UPD:
            begin
                ram_re         = 1'b1;
                cmp_valid_next = 1'b1;
                cmp_addr_next  = ram_raddr;
                idx_next       = idx_reg + bdq_pkg::CNT_W'(1);
                if (last_idx)
                begin
                    state_next = bdq_pkg::ENG_UPD_WAIT;
                end
            end
            bdq_pkg::ENG_UPD_WAIT:
            begin
                idx_next   = '0;
                state_next = bdq_pkg::ENG_READ;
            end
            bdq_pkg::ENG_READ:
            begin
                if (credit)
                begin
                    ram_re                           = !empty;
                    stage_valid_next                 = 1'b1;
                    stage_meta_next.status           = status_reg;
                    stage_meta_next.entry_count      = 5'(count_reg);
                    stage_meta_next.element_position = empty ? 4'd0 : 4'(idx_reg);
                    stage_meta_next.list_empty       = empty;
                    stage_meta_next.last             = empty || last_idx;
                    if (empty || last_idx)
                    begin
                        state_next = bdq_pkg::ENG_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + bdq_pkg::CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = bdq_pkg::ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bdq_pkg::ENG_IDLE;
            front_reg       <= '0;
            count_reg       <= '0;
            cmp_valid_reg   <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            front_reg       <= front_next;
            count_reg       <= count_next;
            cmp_valid_reg   <= cmp_valid_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        item_reg       <= item_next;
        match_reg      <= match_next;
        idx_reg        <= idx_next;
        cmp_addr_reg   <= cmp_addr_next;
        stage_meta_reg <= stage_meta_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
        else $error("entry count exceeds depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> ($past(state_reg) == bdq_pkg::ENG_UPD))
        else $error("compare write outside update walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bdq_pkg::ENG_IDLE) |-> !cmp_valid_reg)
        else $error("update write still pending at command accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && stage_meta_reg.list_empty) |-> stage_meta_reg.last)
        else $error("empty readout not marked last");

endmodule

/* rtl/bounded_deque_with_update_top.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_update_top
// Bounded double-ended queue of signed 32-bit values held in a ring buffer
// RAM, with insert, delete and in-place update commands and full readout.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command item: tuser is the action code, tdata holds
//   item_value, match_value and position. After each command the whole list
//   is sent on m_axis, front first, one item per entry; tlast marks the final
//   item. An empty list gives a single item with tuser (list_empty) set.
//   The first readout item follows the accepted command through the stage
//   register and the output queue; update by value first runs its compare
//   walk, which reads one RAM entry per cycle.
//   The readout walk streams one entry per cycle through the single RAM
//   read port while the output queue has room, and pauses otherwise.
//   s_axis_tready is high only while no command is being worked on.
//   Reset clears the pointers and count (list empty); no clearing pass.
//   When the receiver stalls, a two-entry output queue holds items and the
//   readout walk pauses; nothing is lost.
// ----------------------------------------------------------------------------
module bounded_deque_with_update_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // item_value, match_value, position
    input  logic [2:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status, entry_count, element, element_position
    output logic [0:0]  m_axis_tuser,   // list_empty
    output logic        m_axis_tlast
);

    bdq_pkg::buf_stat_t           buf_stat;
    bdq_pkg::out_item_t           push_item;
    bdq_pkg::out_item_t           out_item;
    logic                         push;
    logic                         ram_we;
    logic [bdq_pkg::PTR_W-1:0]    ram_waddr;
    logic [bdq_pkg::DATA_W-1:0]   ram_wdata;
    logic                         ram_re;
    logic [bdq_pkg::PTR_W-1:0]    ram_raddr;
    logic [bdq_pkg::DATA_W-1:0]   ram_rdata;

    bdq_ram #(
        .WIDTH   (bdq_pkg::DATA_W),
        .ENTRIES (bdq_pkg::DEPTH),
        .ADDR_W  (bdq_pkg::PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bdq_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .action      (s_axis_tuser),
        .item_value  (s_axis_tdata[31:0]),
        .match_value (s_axis_tdata[63:32]),
        .position    (s_axis_tdata[67:64]),
        .buf_stat    (buf_stat),
        .push        (push),
        .push_item   (push_item),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    bdq_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .stat      (buf_stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = {5'd0,
                           out_item.meta.element_position,
                           out_item.element,
                           out_item.meta.entry_count,
                           out_item.meta.status};
    assign m_axis_tuser = out_item.meta.list_empty;
    assign m_axis_tlast = out_item.meta.last;

endmodule
